/* src/assert_macros.svh */
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define SXFD_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define SXFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/sxfd_pkg.sv */
package sxfd_pkg;

    localparam int SCREEN_COLUMNS = 64;
    localparam int SCREEN_ROWS    = 32;

    localparam int COL_W      = (SCREEN_COLUMNS > 1) ? $clog2(SCREEN_COLUMNS) : 1;
    localparam int ROW_W      = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
    localparam int ROW_DATA_W = 64;
    localparam int SPRITE_W   = 8;
    localparam int WRAP_W     = 12;
    localparam int WRAP_STEPS = 6;

    typedef enum logic [0:0] {
        OP_DRAW = 1'b0,
        OP_READ = 1'b1
    } t_opcode;

    typedef struct packed {
        logic                valid;
        t_opcode             op;
        logic [ROW_W-1:0]    line;
        logic [COL_W-1:0]    x;
        logic [SPRITE_W-1:0] bits;
        logic                clear;
    } t_stage;

    // Restoring reduction by a constant modulus, one compare and subtract per step.
    function automatic logic [WRAP_W-1:0] wrap_value(input logic [WRAP_W-1:0] value,
                                                     input logic [WRAP_W-1:0] modulus);
        logic [WRAP_W-1:0] rem;
        logic [WRAP_W-1:0] step;
        int                k;
        rem = value;
        for (k = WRAP_STEPS - 1; k >= 0; k--) begin
            step = modulus << k;
            if (rem >= step) begin
                rem = rem - step;
            end
        end
        return rem;
    endfunction

endpackage

/* src/sxfd_ram.sv */
module sxfd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/sprite_xor_framebuffer_draw.sv */
// XOR sprite frame store. One transaction is taken per clock cycle whenever
// busy is low; busy is high only during reset and the first cycle after it.
// Each transaction returns exactly one result through r_s1 and then r_done,
// marked by o_done for a single cycle; the receiver cannot stall, so results
// must be captured when o_done is high. The frame store is one RAM word per
// display line: the line is read in the cycle a transaction is taken and the
// modified word is written back in the next cycle, with the last written word
// forwarded to a following transaction on the same line. Lines never written
// since reset read as blank through per-line valid bits, so no clearing pass
// is needed. o_collision is the collision flag after the transaction; o_row_data
// holds the display line for a read and zero for a draw.
module sprite_xor_framebuffer_draw import sxfd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_opcode,
    input  logic [7:0]            i_x_origin,
    input  logic [7:0]            i_y_origin,
    input  logic [3:0]            i_row_offset,
    input  logic [SPRITE_W-1:0]   i_row_bits,
    output logic                  o_done,
    output logic                  o_collision,
    output logic [ROW_DATA_W-1:0] o_row_data
);

    logic                      r_busy;
    logic                      accept;
    t_opcode                   acc_op;
    logic [8:0]                acc_sum;
    logic [WRAP_W-1:0]         line_wrap;
    logic [WRAP_W-1:0]         col_wrap;
    t_stage                    r_s1;
    t_stage                    n_s1;

    logic [SCREEN_COLUMNS-1:0] ram_rdata;
    logic                      wr_en;
    logic [SCREEN_COLUMNS-1:0] cur_word;
    logic [SCREEN_COLUMNS-1:0] new_word;
    logic [SCREEN_COLUMNS-1:0] mask;
    logic                      hit;

    logic                      r_fwd_valid;
    logic [ROW_W-1:0]          r_fwd_line;
    logic [SCREEN_COLUMNS-1:0] r_fwd_word;
    logic [SCREEN_ROWS-1:0]    r_row_valid;

    logic                      r_collision;
    logic                      n_collision;
    logic                      r_done;
    logic [ROW_DATA_W-1:0]     r_row_data;
    logic [ROW_DATA_W-1:0]     n_row_data;

    assign busy   = r_busy;
    assign accept = start & ~r_busy;
    assign acc_op = t_opcode'(i_opcode);

    always_comb begin
        if (acc_op == OP_READ) begin
            acc_sum = {1'b0, i_y_origin};
        end else begin
            acc_sum = {1'b0, i_y_origin} + {5'b0, i_row_offset};
        end
        line_wrap = wrap_value({3'b0, acc_sum}, WRAP_W'(SCREEN_ROWS));
        col_wrap  = wrap_value({4'b0, i_x_origin}, WRAP_W'(SCREEN_COLUMNS));

        n_s1.valid = accept;
        n_s1.op    = acc_op;
        n_s1.line  = line_wrap[ROW_W-1:0];
        n_s1.x     = col_wrap[COL_W-1:0];
        n_s1.bits  = i_row_bits;
        n_s1.clear = (i_row_offset == 4'd0);
    end

    sxfd_ram #(
        .WIDTH (SCREEN_COLUMNS),
        .DEPTH (SCREEN_ROWS)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1.line),
        .i_wdata (new_word),
        .i_raddr (n_s1.line),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        logic [COL_W:0] col;
        int             i;
        if (r_fwd_valid && (r_fwd_line == r_s1.line)) begin
            cur_word = r_fwd_word;
        end else if (r_row_valid[r_s1.line]) begin
            cur_word = ram_rdata;
        end else begin
            cur_word = '0;
        end

        mask = '0;
        for (i = 0; i < SPRITE_W; i++) begin
            col = {1'b0, r_s1.x} + (COL_W+1)'(i);
            if (col >= (COL_W+1)'(SCREEN_COLUMNS)) begin
                col = col - (COL_W+1)'(SCREEN_COLUMNS);
            end
            if (r_s1.bits[3'(SPRITE_W - 1 - i)]) begin
                mask[col[COL_W-1:0]] = 1'b1;
            end
        end

        new_word = cur_word ^ mask;
        hit      = |(cur_word & mask);
        wr_en    = r_s1.valid && (r_s1.op == OP_DRAW);

        n_collision = r_collision;
        if (wr_en) begin
            n_collision = (r_s1.clear ? 1'b0 : r_collision) | hit;
        end

        if (r_s1.op == OP_READ) begin
            n_row_data = ROW_DATA_W'(cur_word);
        end else begin
            n_row_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b1;
            r_s1        <= '0;
            r_fwd_valid <= 1'b0;
            r_row_valid <= '0;
            r_collision <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_busy      <= 1'b0;
            r_s1        <= n_s1;
            r_fwd_valid <= wr_en;
            if (wr_en) begin
                r_row_valid[r_s1.line] <= 1'b1;
            end
            r_collision <= n_collision;
            r_done      <= r_s1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_line <= r_s1.line;
        r_fwd_word <= new_word;
        r_row_data <= n_row_data;
    end

    assign o_done      = r_done;
    assign o_collision = r_collision;
    assign o_row_data  = r_row_data;

endmodule

/* src/sxfd_checker.sv */
`include "assert_macros.svh"

module sxfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_opcode,
    input logic        o_done,
    input logic [63:0] o_row_data
);

    `SXFD_ASSERT_ALWAYS(a_result_follows, i_clk, i_rst_n, ((start && !busy) |-> ##2 o_done), "taken transaction did not give a result two cycles later")
    `SXFD_ASSERT_ALWAYS(a_result_has_cause, i_clk, i_rst_n, (o_done |-> $past(start && !busy, 2)), "result without a transaction taken two cycles earlier")
    `SXFD_ASSERT_ALWAYS(a_draw_data_zero, i_clk, i_rst_n, ((o_done && $past(i_opcode == 1'b0, 2)) |-> (o_row_data == 64'd0)), "draw result carries row data")
    `SXFD_ASSERT_NEXT(a_busy_stays_low, i_clk, i_rst_n, !busy, !busy, "busy rose outside reset")

endmodule

bind sprite_xor_framebuffer_draw sxfd_checker u_sxfd_checker (.*);
